// File: rtl/core/pbdq_pkg.sv
// Package for the percentile byte dequantizer: shared types, constants and
// the Q16.16 saturation helper. No dependencies.
`default_nettype none

package pbdq_pkg;

  // Matrix geometry and stream layout
  localparam logic [15:0] COLUMNS   = 16'd40;
  localparam logic [2:0]  HDR_WORDS = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_GLOBAL_MIN   = 2'd0;
  localparam logic [1:0] REG_GLOBAL_RANGE = 2'd1;
  localparam logic [1:0] REG_ROWS_PER_COL = 2'd2;

  // Reset values of the configuration registers
  localparam logic signed [31:0] GLOBAL_MIN_RST   = 32'sd0;
  localparam logic signed [31:0] GLOBAL_RANGE_RST = 32'sd65536;
  localparam logic [15:0]        ROWS_PER_COL_RST = 16'd1;

  // Code byte segment boundaries
  localparam logic [7:0] CODE_LOW_TOP = 8'd64;
  localparam logic [7:0] CODE_MID_TOP = 8'd192;

  // Segment codes
  localparam logic [1:0] SEG_LOW  = 2'd0;
  localparam logic [1:0] SEG_MID  = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;

  // Divisor of the upper segment, and of a header word
  localparam logic [7:0]  DIV_HIGH = 8'd63;
  localparam logic [17:0] DIV_HDR  = 18'd65535;

  localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

  // One stream word with its decoded role and column flags
  typedef struct packed {
    logic        hdr;
    logic [1:0]  idx;
    logic [15:0] word;
    logic        lic;
    logic        lim;
  } item_t;

  // The four percentiles of the current column
  typedef struct packed {
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
  } pct_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pbdq_ctrl.sv
// Stream control: configuration registers, header/row/column counters and
// the input register. Depends on pbdq_pkg.
`default_nettype none

module pbdq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                accept_i,
  input  wire logic                ld_i,
  input  wire logic [15:0]         word_i,
  output pbdq_pkg::item_t          item_o,
  output logic signed [31:0]       global_min_o,
  output logic signed [31:0]       global_range_o
);

  logic signed [31:0] gmin_q, grange_q;
  logic [15:0]        rows_q;
  logic [2:0]         hc_q, hc_d;
  logic [15:0]        row_q, row_d;
  logic [15:0]        col_q, col_d;
  logic [15:0]        row_inc, col_inc;
  pbdq_pkg::item_t    item_d, item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gmin_q   <= pbdq_pkg::GLOBAL_MIN_RST;
      grange_q <= pbdq_pkg::GLOBAL_RANGE_RST;
      rows_q   <= pbdq_pkg::ROWS_PER_COL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pbdq_pkg::REG_GLOBAL_MIN:   gmin_q   <= cfg_data_i;
        pbdq_pkg::REG_GLOBAL_RANGE: grange_q <= cfg_data_i;
        pbdq_pkg::REG_ROWS_PER_COL: rows_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign row_inc = row_q + 16'd1;
  assign col_inc = col_q + 16'd1;

  always_comb begin
    item_d      = '0;
    item_d.word = word_i;
    item_d.idx  = hc_q[1:0];
    hc_d        = hc_q;
    row_d       = row_q;
    col_d       = col_q;
    if (hc_q < pbdq_pkg::HDR_WORDS) begin
      item_d.hdr = 1'b1;
      hc_d       = hc_q + 3'd1;
    end else if (row_inc == rows_q) begin
      // a zero row count only matches after the counter wraps
      item_d.lic = 1'b1;
      row_d      = '0;
      hc_d       = '0;
      if (col_inc == pbdq_pkg::COLUMNS) begin
        item_d.lim = 1'b1;
        col_d      = '0;
      end else begin
        col_d = col_inc;
      end
    end else begin
      row_d = row_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      hc_q  <= hc_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      item_q <= item_d;
    end
  end

  assign item_o         = item_q;
  assign global_min_o   = gmin_q;
  assign global_range_o = grange_q;

endmodule

`default_nettype wire

// File: rtl/core/pbdq_hdr.sv
// Header path: percentile = sat(min + trunc(range * word / 65535)) over three
// stages, plus the four-entry percentile store. Depends on pbdq_pkg.
`default_nettype none

module pbdq_hdr (
  input  wire logic               clk_i,
  input  wire logic               ld1_i,
  input  wire logic               ld2_i,
  input  wire logic               we_i,
  input  wire logic [1:0]         idx_i,
  input  wire logic [15:0]        word_i,
  input  wire logic signed [31:0] global_min_i,
  input  wire logic signed [31:0] global_range_i,
  output pbdq_pkg::pct_t          pct_o
);

  // stage 1: product
  logic signed [48:0] prod1_d, prod1_q;
  // stage 2: magnitude and quotient estimate
  logic [48:0]        abs2;
  logic [47:0]        mag2_d, mag2_q;
  logic [48:0]        sum2;
  logic [32:0]        q2_q;
  logic               neg2_q;
  // stage 3: correction, sign, offset, saturation
  logic [49:0]        rem3;
  logic               fix3;
  logic [33:0]        qc3;
  logic signed [35:0] qs3, val3;
  pbdq_pkg::pct_t     pct_q;

  assign prod1_d = global_range_i * $signed({1'b0, word_i});

  always_ff @(posedge clk_i) begin
    if (ld1_i) begin
      prod1_q <= prod1_d;
    end
  end

  // x/65535 = x/2^16 * (1 + 2^-16 + 2^-32 + ...); the estimate is at most one low
  assign abs2   = prod1_q[48] ? (49'd0 - prod1_q) : prod1_q;
  assign mag2_d = abs2[47:0];
  assign sum2   = {1'b0, mag2_d} + {17'b0, mag2_d[47:16]} + {33'b0, mag2_d[47:32]};

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      mag2_q <= mag2_d;
      q2_q   <= sum2[48:16];
      neg2_q <= prod1_q[48];
    end
  end

  assign rem3 = {2'b0, mag2_q} - {1'b0, q2_q, 16'b0} + {17'b0, q2_q};
  assign fix3 = (rem3[17:0] >= pbdq_pkg::DIV_HDR);
  assign qc3  = {1'b0, q2_q} + {33'b0, fix3};
  assign qs3  = neg2_q ? $signed(36'd0 - {2'b0, qc3}) : $signed({2'b0, qc3});
  assign val3 = $signed({{4{global_min_i[31]}}, global_min_i}) + qs3;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      case (idx_i)
        2'd0:    pct_q.p0 <= pbdq_pkg::sat32(val3);
        2'd1:    pct_q.p1 <= pbdq_pkg::sat32(val3);
        2'd2:    pct_q.p2 <= pbdq_pkg::sat32(val3);
        default: pct_q.p3 <= pbdq_pkg::sat32(val3);
      endcase
    end
  end

  assign pct_o = pct_q;

endmodule

`default_nettype wire

// File: rtl/core/pbdq_interp.sv
// Code byte path: segment select and multiply, truncating division by
// 64, 128 or 63, offset and saturation into the result register. Depends on pbdq_pkg.
`default_nettype none

module pbdq_interp (
  input  wire logic        clk_i,
  input  wire logic        ld4_i,
  input  wire logic        ld5_i,
  input  wire logic        ld6_i,
  input  wire pbdq_pkg::item_t item_i,
  input  wire pbdq_pkg::pct_t  pct_i,
  output logic signed [31:0] value_o,
  output logic             lic_o,
  output logic             lim_o
);

  logic [7:0]         code;
  logic [1:0]         seg3;
  logic [7:0]         off3;
  logic signed [31:0] lo3, hi3;
  logic signed [32:0] diff3;
  logic signed [40:0] prod3;

  logic signed [40:0] prod4_q;
  logic signed [31:0] base4_q;
  logic [1:0]         seg4_q;
  logic               lic4_q, lim4_q;
  logic [40:0]        abs4;
  logic [39:0]        mag4;
  logic [40:0]        sum4;
  logic [33:0]        q4;

  logic [39:0]        mag5_q;
  logic [33:0]        q5_q;
  logic               neg5_q;
  logic [1:0]         seg5_q;
  logic signed [31:0] base5_q;
  logic               lic5_q, lim5_q;
  logic [41:0]        rem5;
  logic               fix5;
  logic [34:0]        qc5;
  logic signed [35:0] qs5, val5;

  logic signed [31:0] value_q;
  logic               lic_q, lim_q;

  assign code = item_i.word[7:0];

  always_comb begin
    if (code <= pbdq_pkg::CODE_LOW_TOP) begin
      seg3 = pbdq_pkg::SEG_LOW;
      lo3  = pct_i.p0;
      hi3  = pct_i.p1;
      off3 = code;
    end else if (code <= pbdq_pkg::CODE_MID_TOP) begin
      seg3 = pbdq_pkg::SEG_MID;
      lo3  = pct_i.p1;
      hi3  = pct_i.p2;
      off3 = code - pbdq_pkg::CODE_LOW_TOP;
    end else begin
      seg3 = pbdq_pkg::SEG_HIGH;
      lo3  = pct_i.p2;
      hi3  = pct_i.p3;
      off3 = code - pbdq_pkg::CODE_MID_TOP;
    end
  end

  assign diff3 = $signed({hi3[31], hi3}) - $signed({lo3[31], lo3});
  assign prod3 = diff3 * $signed({1'b0, off3});

  always_ff @(posedge clk_i) begin
    if (ld4_i) begin
      prod4_q <= prod3;
      base4_q <= lo3;
      seg4_q  <= seg3;
      lic4_q  <= item_i.lic;
      lim4_q  <= item_i.lim;
    end
  end

  // divide the magnitude, then restore the sign: truncation toward zero
  assign abs4 = prod4_q[40] ? (41'd0 - prod4_q) : prod4_q;
  assign mag4 = abs4[39:0];
  // x/63 = x/64 * (1 + 2^-6 + 2^-12 + ...); at most one low before correction
  assign sum4 = {1'b0, mag4} + {7'b0, mag4[39:6]} + {13'b0, mag4[39:12]}
              + {19'b0, mag4[39:18]} + {25'b0, mag4[39:24]} + {31'b0, mag4[39:30]}
              + {37'b0, mag4[39:36]};

  always_comb begin
    case (seg4_q)
      pbdq_pkg::SEG_LOW: q4 = mag4[39:6];
      pbdq_pkg::SEG_MID: q4 = {1'b0, mag4[39:7]};
      default:           q4 = sum4[39:6];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld5_i) begin
      mag5_q  <= mag4;
      q5_q    <= q4;
      neg5_q  <= prod4_q[40];
      seg5_q  <= seg4_q;
      base5_q <= base4_q;
      lic5_q  <= lic4_q;
      lim5_q  <= lim4_q;
    end
  end

  assign rem5 = {2'b0, mag5_q} - {2'b0, q5_q, 6'b0} + {8'b0, q5_q};
  assign fix5 = (seg5_q == pbdq_pkg::SEG_HIGH) && (rem5[7:0] >= pbdq_pkg::DIV_HIGH);
  assign qc5  = {1'b0, q5_q} + {34'b0, fix5};
  assign qs5  = neg5_q ? $signed(36'd0 - {1'b0, qc5}) : $signed({1'b0, qc5});
  assign val5 = $signed({{4{base5_q[31]}}, base5_q}) + qs5;

  always_ff @(posedge clk_i) begin
    if (ld6_i) begin
      value_q <= pbdq_pkg::sat32(val5);
      lic_q   <= lic5_q;
      lim_q   <= lim5_q;
    end
  end

  assign value_o = value_q;
  assign lic_o   = lic_q;
  assign lim_o   = lim_q;

endmodule

`default_nettype wire

// File: rtl/core/percentile_byte_dequantizer.sv
// Percentile byte dequantizer, top level: handshake and stage valid chain.
// Depends on pbdq_pkg, pbdq_ctrl, pbdq_hdr and pbdq_interp.
//
// Takes one stream word per cycle, sustained while the output does not
// stall. Each column opens with four header words that set the column's
// percentiles and give no result; the code bytes that follow each give one
// Q16.16 result, with flags for the last row of a column and of the matrix.
// A result passes through the input register and the six stages behind it
// (multiply, divide estimate, then correct and store for headers as they
// leave the second stage; select and multiply, divide, correct and saturate
// for code bytes in the last four). A stalled output fills the empty stages
// first, so the input keeps taking words until the pipeline is full.
// Configuration writes are always accepted and belong to idle time.
`default_nettype none

module percentile_byte_dequantizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] value_o,
  output logic             last_in_column_o,
  output logic             last_in_matrix_o
);

  logic [6:0]         v_q;
  logic [6:0]         rdy;
  logic               accept;
  pbdq_pkg::item_t    s0, s1_q, s2_q, s3_q;
  pbdq_pkg::pct_t     pct;
  logic signed [31:0] gmin, grange;
  logic               hdr_we;

  // a stage loads when it is empty or its contents move on
  assign rdy[6] = !v_q[6] || !out_stall_i;
  assign rdy[5] = !v_q[5] || rdy[6];
  assign rdy[4] = !v_q[4] || rdy[5];
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign accept      = in_valid_i && rdy[0];
  assign in_stall_o  = !rdy[0];
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = v_q[6];
  // header requests write their percentile as they leave stage two
  assign hdr_we      = v_q[2] && s2_q.hdr && rdy[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3] && !s3_q.hdr;
      if (rdy[5]) v_q[5] <= v_q[4];
      if (rdy[6]) v_q[6] <= v_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) s1_q <= s0;
    if (rdy[2]) s2_q <= s1_q;
    if (rdy[3]) s3_q <= s2_q;
  end

  pbdq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .ld_i           (rdy[0]),
    .word_i         (word_i),
    .item_o         (s0),
    .global_min_o   (gmin),
    .global_range_o (grange)
  );

  pbdq_hdr u_hdr (
    .clk_i          (clk_i),
    .ld1_i          (rdy[1]),
    .ld2_i          (rdy[2]),
    .we_i           (hdr_we),
    .idx_i          (s2_q.idx),
    .word_i         (s0.word),
    .global_min_i   (gmin),
    .global_range_i (grange),
    .pct_o          (pct)
  );

  pbdq_interp u_interp (
    .clk_i   (clk_i),
    .ld4_i   (rdy[4]),
    .ld5_i   (rdy[5]),
    .ld6_i   (rdy[6]),
    .item_i  (s3_q),
    .pct_i   (pct),
    .value_o (value_o),
    .lic_o   (last_in_column_o),
    .lim_o   (last_in_matrix_o)
  );

  a_lim_implies_lic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_in_matrix_o |-> last_in_column_o)
    else $error("matrix end flagged without column end");

  a_hdr_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && s3_q.hdr && rdy[4] |=> !v_q[4])
    else $error("header request passed into the code path");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> !in_stall_o)
    else $error("input stalled with an empty input stage");

endmodule

`default_nettype wire
